// File: rtl/latency_histogram_percentile_assert.svh
// ----------------------------------------------------------------------------
// Latency histogram assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LATENCY_HISTOGRAM_PERCENTILE_ASSERT_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_ASSERT_SVH
`ifndef SYNTH
`define LHP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lhp assertion failed");
`define LHP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lhp assertion failed");
`else
`define LHP_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define LHP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/lhp_pkg.sv
// ----------------------------------------------------------------------------
// Latency histogram package
// Shared types and constants of the histogram front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none
package lhp_pkg;

  localparam int unsigned BUCKETS_DEFAULT = 256;
  localparam int unsigned IDX_FIELD_W     = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam logic [23:0] WIDTH_RESET     = 24'd1000;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic                   cmd;
    logic                   in_range;
    logic [IDX_FIELD_W-1:0] idx;
    logic [31:0]            lat;
    logic [13:0]            pct;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage
`default_nettype wire

// File: rtl/lhp_if.sv
// ----------------------------------------------------------------------------
// Latency histogram stream interfaces
// Valid/ready channels for sample/query items and for query results.
// ----------------------------------------------------------------------------
`default_nettype none
interface lhp_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] sample_ns;
  logic [13:0] percent_hundredths;

  modport source (output valid, cmd, sample_ns, percent_hundredths, input ready);
  modport sink   (input valid, cmd, sample_ns, percent_hundredths, output ready);
endinterface

interface lhp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] percentile_ns;
  logic [39:0] mean_fixed;
  logic [31:0] min_latency;
  logic [31:0] max_latency;
  logic [31:0] sample_count;
  logic [31:0] overflow_count;

  modport source (output valid, percentile_ns, mean_fixed, min_latency, max_latency,
                  sample_count, overflow_count, input ready);
  modport sink   (input valid, percentile_ns, mean_fixed, min_latency, max_latency,
                  sample_count, overflow_count, output ready);
endinterface
`default_nettype wire

// File: rtl/lhp_fifo.sv
// ----------------------------------------------------------------------------
// Latency histogram op queue
// Short queue of classified ops between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module lhp_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire lhp_pkg::op_t       op_i,
  input  wire logic               pop_i,
  output lhp_pkg::op_t            op_o,
  output lhp_pkg::fifo_status_t   status_o
);
  localparam int PTRW = (lhp_pkg::QUEUE_DEPTH > 1) ? $clog2(lhp_pkg::QUEUE_DEPTH) : 1;
  localparam logic [PTRW:0] FULL_CNT = (PTRW+1)'(lhp_pkg::QUEUE_DEPTH);

  lhp_pkg::op_t  entry_q [lhp_pkg::QUEUE_DEPTH];
  logic [PTRW-1:0] wptr_q, rptr_q;
  logic [PTRW:0]   cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == FULL_CNT);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign op_o    = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTRW'(lhp_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTRW'(lhp_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/lhp_front.sv
// ----------------------------------------------------------------------------
// Latency histogram front
// Accepts items and finds the bucket of a sample by restoring division.
// ----------------------------------------------------------------------------
`default_nettype none
module lhp_front #(
  parameter int unsigned BUCKETS = lhp_pkg::BUCKETS_DEFAULT
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [23:0]  width_i,
  input  wire logic         hold_i,
  lhp_in_if.sink            in_ch,
  input  wire logic         full_i,
  output logic              push_o,
  output lhp_pkg::op_t      op_o
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e     state_q;
  logic        cmd_q;
  logic [31:0] dvd_q;
  logic [31:0] quo_q;
  logic [23:0] rem_q;
  logic [31:0] lat_q;
  logic [13:0] pct_q;
  logic [4:0]  step_q;
  logic [24:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, dvd_q[31]};
  assign ge     = (rem_sh >= {1'b0, width_i});

  assign in_ch.ready  = (state_q == F_IDLE) && !hold_i;
  assign push_o       = (state_q == F_PUSH);
  assign op_o.cmd     = cmd_q;
  assign op_o.in_range = (quo_q < 32'(BUCKETS));
  assign op_o.idx     = quo_q[lhp_pkg::IDX_FIELD_W-1:0];
  assign op_o.lat     = lat_q;
  assign op_o.pct     = pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cmd_q   <= lhp_pkg::CMD_RECORD;
      dvd_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      lat_q   <= '0;
      pct_q   <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cmd_q  <= in_ch.cmd;
            lat_q  <= in_ch.sample_ns;
            pct_q  <= in_ch.percent_hundredths;
            dvd_q  <= in_ch.sample_ns;
            quo_q  <= '0;
            rem_q  <= '0;
            step_q <= '0;
            state_q <= (in_ch.cmd == lhp_pkg::CMD_RECORD) ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          // one quotient bit per cycle
          rem_q  <= ge ? 24'(rem_sh - {1'b0, width_i}) : rem_sh[23:0];
          quo_q  <= {quo_q[30:0], ge};
          dvd_q  <= {dvd_q[30:0], 1'b0};
          step_q <= step_q + 1'b1;
          if (step_q == 5'd31) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/lhp_back.sv
// ----------------------------------------------------------------------------
// Latency histogram back
// Holds the bucket memory and counters; records samples and answers queries.
// ----------------------------------------------------------------------------
`default_nettype none
module lhp_back #(
  parameter int unsigned BUCKETS = lhp_pkg::BUCKETS_DEFAULT
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [23:0]   width_i,
  input  wire lhp_pkg::op_t  op_i,
  input  wire logic          op_valid_i,
  output logic               op_pop_o,
  output lhp_pkg::back_status_t status_o,
  lhp_out_if.source          out_ch
);
  localparam int IDXW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [IDXW:0] N_BKT    = (IDXW+1)'(BUCKETS);
  localparam logic [IDXW:0] LAST_BKT = (IDXW+1)'(BUCKETS - 1);
  localparam int NUM_W = 136;
  localparam logic [7:0] DIV_LAST = 8'(NUM_W - 1);
  localparam logic [31:0] M32 = 32'hFFFF_FFFF;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_REC_RD = 7'b0000100,
    S_REC_WR = 7'b0001000,
    S_SWEEP  = 7'b0010000,
    S_MUL    = 7'b0100000,
    S_DIV    = 7'b1000000
  } bstate_e;

  bstate_e       state_q;
  logic [31:0]   mem_q [BUCKETS];
  logic [31:0]   rdata_q;
  logic          mem_we;
  logic [IDXW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;

  logic [31:0]   total_q, ovf_q, min_q, max_q;
  logic [IDXW:0] cnt_q;
  logic [IDXW-1:0] rec_idx_q, idx1_q;
  logic          v1_q, v2_q;
  logic [45:0]   target_q;
  logic [63:0]   run_q;
  logic [47:0]   prod_q;
  logic [95:0]   a_q;
  logic [39:0]   edge_q, pct_edge_q;
  logic          found_q;
  logic [2:0]    step_q;
  logic [63:0]   mprod_q;
  logic [1:0]    mshift_q;
  logic          mval_q;
  logic [127:0]  s_q;
  logic [NUM_W-1:0] num_q;
  logic [31:0]   rem_q;
  logic [39:0]   quo_q;
  logic          sat_q;
  logic [7:0]    dcnt_q;
  logic          out_valid_q;
  logic [31:0]   o_pct_q, o_min_q, o_max_q, o_cnt_q, o_ovf_q;
  logic [39:0]   o_mean_q;

  logic [31:0]   mul_a, mul_b;
  logic [1:0]    mul_sh;
  logic          mul_go;
  logic [32:0]   rem_sh;
  logic          ge;
  logic [39:0]   quo_n;
  logic          sat_n;
  logic          reach;

  assign status_o.clearing = (state_q == S_CLEAR);
  assign out_ch.valid          = out_valid_q;
  assign out_ch.percentile_ns  = o_pct_q;
  assign out_ch.mean_fixed     = o_mean_q;
  assign out_ch.min_latency    = o_min_q;
  assign out_ch.max_latency    = o_max_q;
  assign out_ch.sample_count   = o_cnt_q;
  assign out_ch.overflow_count = o_ovf_q;

  // Take a record whenever idle; a query only once the result register is free.
  assign op_pop_o = (state_q == S_IDLE) && op_valid_i &&
                    ((op_i.cmd == lhp_pkg::CMD_RECORD) || !out_valid_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rec_idx_q;
    mem_wdata = (rdata_q == M32) ? rdata_q : rdata_q + 32'd1;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q[IDXW-1:0];
      mem_wdata = '0;
    end else if (state_q == S_REC_WR) begin
      mem_we = 1'b1;
    end
  end
  assign mem_raddr = (state_q == S_SWEEP) ? cnt_q[IDXW-1:0] : rec_idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = 2'd0;
    mul_go = 1'b1;
    case (step_q)
      3'd0: begin mul_a = 32'(width_i); mul_b = a_q[31:0]; end
      3'd1: begin mul_a = 32'(width_i); mul_b = a_q[63:32]; mul_sh = 2'd1; end
      3'd2: begin mul_a = 32'(width_i); mul_b = a_q[95:64]; mul_sh = 2'd2; end
      3'd3: begin mul_a = 32'(width_i[23:1]); mul_b = run_q[31:0]; end
      3'd4: begin mul_a = 32'(width_i[23:1]); mul_b = run_q[63:32]; mul_sh = 2'd1; end
      3'd5: begin mul_a = ovf_q; mul_b = max_q; end
      default: mul_go = 1'b0;
    endcase
  end

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, total_q});
  assign quo_n  = {quo_q[38:0], ge};
  assign sat_n  = sat_q | quo_q[39];
  assign reach  = ((run_q * 64'd10000) >= {18'b0, target_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      total_q     <= '0;
      ovf_q       <= '0;
      min_q       <= M32;
      max_q       <= '0;
      cnt_q       <= '0;
      rec_idx_q   <= '0;
      idx1_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      target_q    <= '0;
      run_q       <= '0;
      prod_q      <= '0;
      a_q         <= '0;
      edge_q      <= '0;
      pct_edge_q  <= '0;
      found_q     <= 1'b0;
      step_q      <= '0;
      mprod_q     <= '0;
      mshift_q    <= '0;
      mval_q      <= 1'b0;
      s_q         <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      sat_q       <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      o_pct_q     <= '0;
      o_mean_q    <= '0;
      o_min_q     <= '0;
      o_max_q     <= '0;
      o_cnt_q     <= '0;
      o_ovf_q     <= '0;
    end else begin
      if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_BKT) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (op_pop_o) begin
            if (op_i.cmd == lhp_pkg::CMD_RECORD) begin
              total_q <= (total_q == M32) ? total_q : total_q + 32'd1;
              if (op_i.lat < min_q) min_q <= op_i.lat;
              if (op_i.lat > max_q) max_q <= op_i.lat;
              if (op_i.in_range) begin
                rec_idx_q <= op_i.idx[IDXW-1:0];
                state_q   <= S_REC_RD;
              end else begin
                ovf_q <= (ovf_q == M32) ? ovf_q : ovf_q + 32'd1;
              end
            end else if (total_q == '0) begin
              out_valid_q <= 1'b1;
              o_pct_q  <= '0;
              o_mean_q <= '0;
              o_min_q  <= '0;
              o_max_q  <= '0;
              o_cnt_q  <= '0;
              o_ovf_q  <= '0;
            end else begin
              target_q <= 46'(total_q) * 46'(op_i.pct);
              run_q    <= '0;
              a_q      <= '0;
              s_q      <= '0;
              edge_q   <= '0;
              found_q  <= 1'b0;
              cnt_q    <= '0;
              v1_q     <= 1'b0;
              v2_q     <= 1'b0;
              state_q  <= S_SWEEP;
            end
          end
        end
        S_REC_RD: state_q <= S_REC_WR;
        S_REC_WR: state_q <= S_IDLE;
        S_SWEEP: begin
          // issue reads, then let the two-stage pipe drain
          if (cnt_q != N_BKT) begin
            v1_q   <= 1'b1;
            idx1_q <= cnt_q[IDXW-1:0];
            cnt_q  <= cnt_q + 1'b1;
          end else begin
            v1_q <= 1'b0;
            if (!v1_q && !v2_q) begin
              step_q  <= '0;
              mval_q  <= 1'b0;
              state_q <= S_MUL;
            end
          end
          v2_q <= v1_q;
          if (v1_q) begin
            run_q  <= run_q + 64'(rdata_q);
            prod_q <= 48'(rdata_q) * 48'(idx1_q);
          end
          if (v2_q) begin
            a_q    <= a_q + 96'(prod_q);
            edge_q <= edge_q + 40'(width_i);
            if (!found_q && reach) begin
              found_q    <= 1'b1;
              pct_edge_q <= edge_q;
            end
          end
        end
        S_MUL: begin
          mval_q   <= mul_go;
          mprod_q  <= 64'(mul_a) * 64'(mul_b);
          mshift_q <= mul_sh;
          if (mval_q) begin
            s_q <= s_q + (128'(mprod_q) << {mshift_q, 5'b0});
          end
          step_q <= step_q + 1'b1;
          if (step_q == 3'd7) begin
            num_q   <= {s_q, 8'b0};
            rem_q   <= '0;
            quo_q   <= '0;
            sat_q   <= 1'b0;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= ge ? 32'(rem_sh - {1'b0, total_q}) : rem_sh[31:0];
          quo_q  <= quo_n;
          sat_q  <= sat_n;
          num_q  <= {num_q[NUM_W-2:0], 1'b0};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DIV_LAST) begin
            out_valid_q <= 1'b1;
            o_mean_q <= sat_n ? 40'hFF_FFFF_FFFF : quo_n;
            o_pct_q  <= !found_q ? max_q :
                        (|pct_edge_q[39:32]) ? M32 : pct_edge_q[31:0];
            o_min_q  <= min_q;
            o_max_q  <= max_q;
            o_cnt_q  <= total_q;
            o_ovf_q  <= ovf_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/latency_histogram_percentile.sv
// ----------------------------------------------------------------------------
// Latency histogram with percentile query
// Bins latency samples, keeps count/min/max/overflow, answers percentile and
// mean queries.
//
//   channel   dir  transfer when     payload
//   in_ch     in   valid & ready     cmd, sample_ns, percent_hundredths
//   out_ch    out  valid & ready     percentile_ns, mean_fixed, min/max, counts
//   cfg       in   cfg_we_i          bucket width (24 bits)
//
// A record is divided in the front (one quotient bit per cycle), then queued;
// the back does the bucket read-modify-write in S_REC_RD and then S_REC_WR.
// A query sweeps the buckets with one bucket read per cycle, sums six partial
// products, then runs a 136-step mean divide before its result is valid.
// After reset a clearing pass zeroes every bucket; no item is taken meanwhile.
// Records keep flowing while a query result waits; a second query waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "latency_histogram_percentile_assert.svh"
module latency_histogram_percentile #(
  parameter int unsigned BUCKETS = lhp_pkg::BUCKETS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  lhp_in_if.sink           in_ch,
  lhp_out_if.source        out_ch
);
  logic [23:0]           width_q;
  logic [23:0]           width_eff;
  logic                  push;
  lhp_pkg::op_t          front_op, queue_op;
  lhp_pkg::fifo_status_t fifo_st;
  lhp_pkg::back_status_t back_st;
  logic                  pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= lhp_pkg::WIDTH_RESET;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  // zero width behaves as width one
  assign width_eff = (width_q == '0) ? 24'd1 : width_q;

  lhp_front #(.BUCKETS(BUCKETS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .width_i (width_eff),
    .hold_i  (back_st.clearing),
    .in_ch   (in_ch),
    .full_i  (fifo_st.full),
    .push_o  (push),
    .op_o    (front_op)
  );

  lhp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .op_i     (front_op),
    .pop_i    (pop),
    .op_o     (queue_op),
    .status_o (fifo_st)
  );

  lhp_back #(.BUCKETS(BUCKETS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_eff),
    .op_i       (queue_op),
    .op_valid_i (!fifo_st.empty),
    .op_pop_o   (pop),
    .status_o   (back_st),
    .out_ch     (out_ch)
  );

  `LHP_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop, !fifo_st.empty)
  `LHP_ASSERT_IMPL(a_clear_holds_in, clk_i, rst_ni, back_st.clearing, !in_ch.ready)
  `LHP_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, out_ch.valid && out_ch.sample_count == 32'd0, out_ch.mean_fixed == 40'd0 && out_ch.percentile_ns == 32'd0)
  `LHP_ASSERT_IMPL(a_min_le_max, clk_i, rst_ni, out_ch.valid && out_ch.sample_count != 32'd0, out_ch.min_latency <= out_ch.max_latency)
endmodule
`default_nettype wire
